@@ rtl/assert_macros.svh @@
// Assertion macros shared by the split finder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define HSF_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: implication check failed");
`define HSF_ASSERT_NEVER(name, clk, rst_n, expr) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
        else $error("%m: forbidden condition seen");
`else
`define HSF_ASSERT_IMPLY(name, clk, rst_n, ante, cons)
`define HSF_ASSERT_NEVER(name, clk, rst_n, expr)
`endif
`endif

@@ rtl/hsf_pkg.sv @@
// Types, constants and helpers of the histogram split finder.
package hsf_pkg;

    localparam int FEATURE_LIMIT = 256;
    localparam int BIN_LIMIT     = 256;
    localparam int QUEUE_DEPTH   = 4;
    localparam int DIV_NUM_W     = 63;
    localparam int DIV_DEN_W     = 33;

    localparam logic signed [31:0] G_MAX    = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] G_MIN    = 32'sh8000_0000;
    localparam logic        [47:0] GAIN_MAX = 48'h7FFF_FFFF_FFFF;

    typedef struct packed {
        logic               op;
        logic        [7:0]  feature;
        logic        [7:0]  bin_index;
        logic signed [31:0] grad_sum;
        logic        [31:0] hess_sum;
        logic        [23:0] sample_count;
        logic               last;
    } t_in_item;

    typedef struct packed {
        logic               split_valid;
        logic        [7:0]  sel_feature;
        logic        [7:0]  sel_bin;
        logic signed [47:0] split_gain;
        logic signed [31:0] left_grad;
        logic        [31:0] left_hess;
        logic        [23:0] left_count;
        logic signed [31:0] right_grad;
        logic        [31:0] right_hess;
        logic        [23:0] right_count;
        logic signed [31:0] leaf_left;
        logic signed [31:0] leaf_right;
    } t_out_item;

    typedef struct packed {
        logic [31:0] lambda_reg;
        logic [31:0] min_hess;
        logic [23:0] min_count;
        logic [31:0] gain_floor;
        logic [8:0]  num_bins;
    } t_cfg;

    typedef enum logic [2:0] {
        REG_LAMBDA      = 3'd0,
        REG_MIN_WEIGHT  = 3'd1,
        REG_MIN_SAMPLES = 3'd2,
        REG_MIN_GAIN    = 3'd3,
        REG_NUM_BINS    = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        JOB_START,
        JOB_CAND,
        JOB_EMIT
    } t_job_kind;

    // lg/lh carry the parent sums for a start request
    typedef struct packed {
        t_job_kind          kind;
        logic               last;
        logic        [7:0]  feature;
        logic        [7:0]  bin_index;
        logic signed [31:0] lg;
        logic        [31:0] lh;
        logic        [23:0] lc;
        logic signed [31:0] rg;
        logic        [31:0] rh;
        logic        [23:0] rc;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_MUL,
        BS_GO,
        BS_WAIT,
        BS_POST,
        BS_GAIN,
        BS_EMIT,
        BS_OUT
    } t_bstate;

    typedef enum logic [2:0] {
        STEP_PS,
        STEP_SL,
        STEP_SR,
        STEP_LL,
        STEP_LR
    } t_step;

    function automatic logic [31:0] mag32(input logic signed [31:0] g);
        logic [31:0] u;
        u = g;
        return g[31] ? (~u + 32'd1) : u;
    endfunction

endpackage

@@ rtl/histogram_split_finder_unit.sv @@
// Histogram best-split finder: configuration registers, front, queue, back.
// Every division runs on one shared 63-step restoring divider and holds the back end
// through operand setup, launch, wait and write-back. A start request takes one
// division in the back end (the parent score) and a threshold candidate two (left
// and right scores, then the compare); the final bin adds an emit step, two
// leaf-value divisions when a split was found, and the output load before the
// result appears.
// Bins that are no threshold candidate and not last finish in the front end. The
// front end takes one request a cycle while the four-entry queue has room, so
// input stall follows queue occupancy, not back-end work.
module histogram_split_finder_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  hsf_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output hsf_pkg::t_out_item o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import hsf_pkg::*;
`include "assert_macros.svh"

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     cfg_wr;
    logic     push;
    t_job     push_job;
    logic     pop;
    t_job     head_job;
    t_q_stat  q_stat;

    always_comb begin
        reg_idx = t_reg_idx'(paddr[4:2]);
        cfg_wr  = psel && penable && pwrite && pready;
        unique case (reg_idx)
            REG_LAMBDA:      prdata = r_cfg.lambda_reg;
            REG_MIN_WEIGHT:  prdata = r_cfg.min_hess;
            REG_MIN_SAMPLES: prdata = {8'd0, r_cfg.min_count};
            REG_MIN_GAIN:    prdata = r_cfg.gain_floor;
            REG_NUM_BINS:    prdata = {23'd0, r_cfg.num_bins};
            default:         prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lambda_reg <= 32'h0001_0000;
            r_cfg.min_hess   <= 32'h0001_0000;
            r_cfg.min_count  <= 24'd20;
            r_cfg.gain_floor <= '0;
            r_cfg.num_bins   <= 9'd256;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_LAMBDA:      r_cfg.lambda_reg <= pwdata;
                REG_MIN_WEIGHT:  r_cfg.min_hess   <= pwdata;
                REG_MIN_SAMPLES: r_cfg.min_count  <= pwdata[23:0];
                REG_MIN_GAIN:    r_cfg.gain_floor <= pwdata;
                REG_NUM_BINS:    r_cfg.num_bins   <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    hsf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_q_full   (q_stat.full),
        .o_push     (push),
        .o_job      (push_job)
    );

    hsf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_stat  (q_stat)
    );

    hsf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job       (head_job),
        .i_q_empty   (q_stat.empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    `HSF_ASSERT_NEVER(a_queue_full_empty, i_clk, i_rst_n, q_stat.full && q_stat.empty)
    `HSF_ASSERT_IMPLY(a_nosplit_zero, i_clk, i_rst_n, o_out_valid && !o_out_data.split_valid, o_out_data.split_gain == '0 && o_out_data.leaf_right == '0)
    `HSF_ASSERT_IMPLY(a_split_bin_range, i_clk, i_rst_n, o_out_valid && o_out_data.split_valid, o_out_data.sel_bin != 8'hFF)
    `HSF_ASSERT_IMPLY(a_stall_is_full, i_clk, i_rst_n, o_in_stall, q_stat.full)
endmodule

@@ rtl/hsf_div.sv @@
// Restoring divider, one quotient bit per cycle.
module hsf_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [hsf_pkg::DIV_NUM_W-1:0]   i_num,
    input  logic [hsf_pkg::DIV_DEN_W-1:0]   i_den,
    output logic                            o_busy,
    output logic [hsf_pkg::DIV_NUM_W-1:0]   o_quot
);
    import hsf_pkg::*;

    localparam int CNT_W = $clog2(DIV_NUM_W + 1);

    logic [DIV_DEN_W:0]   r_rem;
    logic [DIV_NUM_W-1:0] r_quo;
    logic [DIV_DEN_W-1:0] r_den;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_busy;

    logic [DIV_DEN_W:0]   trial;
    logic                 fits;

    always_comb begin
        trial = {r_rem[DIV_DEN_W-1:0], r_quo[DIV_NUM_W-1]};
        fits  = trial >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_rem  <= '0;
            r_quo  <= i_num;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_rem <= fits ? (trial - {1'b0, r_den}) : trial;
            r_quo <= {r_quo[DIV_NUM_W-2:0], fits};
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(DIV_NUM_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quo;
endmodule

@@ rtl/hsf_queue.sv @@
// Short request queue between front and back.
module hsf_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  hsf_pkg::t_job   i_job,
    input  logic            i_pop,
    output hsf_pkg::t_job   o_job,
    output hsf_pkg::t_q_stat o_stat
);
    import hsf_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(i_pop);
        end
    end

    assign o_job        = r_mem[r_rd_ptr];
    assign o_stat.full  = r_count == CNT_W'(QUEUE_DEPTH);
    assign o_stat.empty = r_count == '0;
endmodule

@@ rtl/hsf_front.sv @@
// Front end: running prefix, right side, limits, request classification.
module hsf_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hsf_pkg::t_cfg     i_cfg,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  hsf_pkg::t_in_item i_in_data,
    input  logic              i_q_full,
    output logic              o_push,
    output hsf_pkg::t_job     o_job
);
    import hsf_pkg::*;

    logic signed [31:0] r_parent_grad;
    logic        [31:0] r_parent_hess;
    logic        [23:0] r_parent_count;
    logic signed [31:0] r_prefix_grad;
    logic        [31:0] r_prefix_hess;
    logic        [23:0] r_prefix_count;

    logic               accept;
    logic               in_range;
    logic signed [31:0] base_g;
    logic        [31:0] base_h;
    logic        [23:0] base_c;
    logic signed [32:0] sum_g;
    logic        [32:0] sum_h;
    logic        [24:0] sum_c;
    logic signed [31:0] lg;
    logic        [31:0] lh;
    logic        [23:0] lc;
    logic signed [32:0] dif_g;
    logic signed [31:0] rg;
    logic        [31:0] rh;
    logic        [23:0] rc;
    logic        [8:0]  nb_m1;
    logic               cand;

    always_comb begin
        accept   = i_in_valid && !i_q_full;
        in_range = {9'd0, i_in_data.feature} < 17'(FEATURE_LIMIT);

        base_g = (i_in_data.bin_index == '0) ? '0 : r_prefix_grad;
        base_h = (i_in_data.bin_index == '0) ? '0 : r_prefix_hess;
        base_c = (i_in_data.bin_index == '0) ? '0 : r_prefix_count;

        sum_g = $signed({base_g[31], base_g}) + $signed({i_in_data.grad_sum[31],
                                                         i_in_data.grad_sum});
        if (sum_g[32] != sum_g[31]) lg = sum_g[32] ? G_MIN : G_MAX;
        else                        lg = sum_g[31:0];
        sum_h = {1'b0, base_h} + {1'b0, i_in_data.hess_sum};
        lh    = sum_h[32] ? '1 : sum_h[31:0];
        sum_c = {1'b0, base_c} + {1'b0, i_in_data.sample_count};
        lc    = sum_c[24] ? '1 : sum_c[23:0];

        dif_g = $signed({r_parent_grad[31], r_parent_grad}) - $signed({lg[31], lg});
        if (dif_g[32] != dif_g[31]) rg = dif_g[32] ? G_MIN : G_MAX;
        else                        rg = dif_g[31:0];
        rh = (r_parent_hess >= lh) ? (r_parent_hess - lh) : '0;
        rc = (r_parent_count >= lc) ? (r_parent_count - lc) : '0;

        // effective bin count clamped to [2, BIN_LIMIT], minus one
        if (i_cfg.num_bins < 9'd2)                  nb_m1 = 9'd1;
        else if (i_cfg.num_bins > 9'(BIN_LIMIT))    nb_m1 = 9'(BIN_LIMIT - 1);
        else                                        nb_m1 = i_cfg.num_bins - 9'd1;

        cand = in_range && ({1'b0, i_in_data.bin_index} < nb_m1)
            && (lc >= i_cfg.min_count) && (rc >= i_cfg.min_count)
            && (lh >= i_cfg.min_hess) && (rh >= i_cfg.min_hess);

        o_job.last      = i_in_data.last;
        o_job.feature   = i_in_data.feature;
        o_job.bin_index = i_in_data.bin_index;
        o_job.rg        = rg;
        o_job.rh        = rh;
        o_job.rc        = rc;
        if (!i_in_data.op) begin
            o_job.kind = JOB_START;
            o_job.lg   = i_in_data.grad_sum;
            o_job.lh   = i_in_data.hess_sum;
            o_job.lc   = i_in_data.sample_count;
        end else begin
            o_job.kind = cand ? JOB_CAND : JOB_EMIT;
            o_job.lg   = lg;
            o_job.lh   = lh;
            o_job.lc   = lc;
        end
        o_push = accept && (!i_in_data.op || cand || i_in_data.last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parent_grad  <= '0;
            r_parent_hess  <= '0;
            r_parent_count <= '0;
            r_prefix_grad  <= '0;
            r_prefix_hess  <= '0;
            r_prefix_count <= '0;
        end else if (accept) begin
            if (!i_in_data.op) begin
                r_parent_grad  <= i_in_data.grad_sum;
                r_parent_hess  <= i_in_data.hess_sum;
                r_parent_count <= i_in_data.sample_count;
                r_prefix_grad  <= '0;
                r_prefix_hess  <= '0;
                r_prefix_count <= '0;
            end else if (in_range) begin
                r_prefix_grad  <= lg;
                r_prefix_hess  <= lh;
                r_prefix_count <= lc;
            end
        end
    end

    assign o_in_stall = i_q_full;
endmodule

@@ rtl/hsf_back.sv @@
// Back end: score and leaf divisions, best-split tracking, result register.
module hsf_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hsf_pkg::t_cfg      i_cfg,
    input  hsf_pkg::t_job      i_job,
    input  logic               i_q_empty,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output hsf_pkg::t_out_item o_out_data
);
    import hsf_pkg::*;

    t_bstate r_state, n_state;
    t_step   r_step;
    t_job    r_job;

    logic        [47:0] r_parent_score;
    logic        [47:0] r_score_l;
    logic        [47:0] r_score_r;
    logic               r_best_valid;
    logic signed [47:0] r_best_gain;
    logic        [7:0]  r_best_feature;
    logic        [7:0]  r_best_bin;
    logic signed [31:0] r_best_lg;
    logic        [31:0] r_best_lh;
    logic        [23:0] r_best_lc;
    logic signed [31:0] r_best_rg;
    logic        [31:0] r_best_rh;
    logic        [23:0] r_best_rc;
    logic signed [31:0] r_leaf_l;
    logic signed [31:0] r_leaf_r;
    logic [DIV_NUM_W-1:0] r_num;
    logic [DIV_DEN_W-1:0] r_den;
    logic               r_mag_zero;
    logic               r_g_pos;
    logic               r_out_valid;
    t_out_item          r_out;

    logic signed [31:0] op_g;
    logic        [31:0] op_h;
    logic        [31:0] mag;
    logic        [63:0] sq;
    logic               div_start;
    logic               div_busy;
    logic [DIV_NUM_W-1:0] quot;
    logic        [47:0] score_val;
    logic signed [31:0] leaf_val;
    logic signed [49:0] gsum;
    logic signed [49:0] gsum_adj;
    logic signed [49:0] ghalf;
    logic signed [47:0] gain;
    logic               better;
    logic               out_free;

    hsf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_busy  (div_busy),
        .o_quot  (quot)
    );

    // operand and result datapath
    always_comb begin
        unique case (r_step)
            STEP_PS, STEP_SL: begin op_g = r_job.lg;   op_h = r_job.lh;   end
            STEP_SR:          begin op_g = r_job.rg;   op_h = r_job.rh;   end
            STEP_LL:          begin op_g = r_best_lg;  op_h = r_best_lh;  end
            STEP_LR:          begin op_g = r_best_rg;  op_h = r_best_rh;  end
            default:          begin op_g = r_job.lg;   op_h = r_job.lh;   end
        endcase
        mag = mag32(op_g);
        sq  = mag * mag;

        if (r_den == '0)                      score_val = r_mag_zero ? '0 : GAIN_MAX;
        else if (quot > DIV_NUM_W'(GAIN_MAX)) score_val = GAIN_MAX;
        else                                  score_val = quot[47:0];

        if (r_mag_zero)         leaf_val = '0;
        else if (r_den == '0)   leaf_val = r_g_pos ? G_MIN : G_MAX;
        else if (r_g_pos)       leaf_val = (quot > DIV_NUM_W'(33'h0_8000_0000)) ? G_MIN
                                                                             : -$signed(quot[31:0]);
        else                    leaf_val = (quot > DIV_NUM_W'(G_MAX)) ? G_MAX
                                                                     : $signed(quot[31:0]);

        // halve toward zero
        gsum     = $signed({2'b00, r_score_l}) + $signed({2'b00, r_score_r})
                 - $signed({2'b00, r_parent_score});
        gsum_adj = gsum + $signed({49'd0, gsum[49]});
        ghalf    = gsum_adj >>> 1;
        gain     = ghalf[47:0];
        better   = (!r_best_valid || gain > r_best_gain)
                && gain >= $signed({16'd0, i_cfg.gain_floor});

        out_free = !r_out_valid || !i_out_stall;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_IDLE: begin
                if (!i_q_empty) begin
                    unique case (i_job.kind)
                        JOB_START, JOB_CAND: n_state = BS_MUL;
                        JOB_EMIT:            n_state = BS_EMIT;
                        default:             n_state = BS_IDLE;
                    endcase
                end
            end
            BS_MUL:  n_state = BS_GO;
            BS_GO:   n_state = BS_WAIT;
            BS_WAIT: if (!div_busy) n_state = BS_POST;
            BS_POST: begin
                unique case (r_step)
                    STEP_PS:          n_state = BS_IDLE;
                    STEP_SL, STEP_LL: n_state = BS_MUL;
                    STEP_SR:          n_state = BS_GAIN;
                    STEP_LR:          n_state = BS_OUT;
                    default:          n_state = BS_IDLE;
                endcase
            end
            BS_GAIN: n_state = r_job.last ? BS_EMIT : BS_IDLE;
            BS_EMIT: n_state = r_best_valid ? BS_MUL : BS_OUT;
            BS_OUT:  if (out_free) n_state = BS_IDLE;
            default: n_state = BS_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_pop     = (r_state == BS_IDLE) && !i_q_empty;
        div_start = (r_state == BS_GO);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= BS_IDLE;
            r_step         <= STEP_PS;
            r_parent_score <= '0;
            r_best_valid   <= 1'b0;
            r_best_gain    <= '0;
            r_best_feature <= '0;
            r_best_bin     <= '0;
            r_best_lg      <= '0;
            r_best_lh      <= '0;
            r_best_lc      <= '0;
            r_best_rg      <= '0;
            r_best_rh      <= '0;
            r_best_rc      <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == BS_OUT && out_free) r_out_valid <= 1'b1;
            else if (!i_out_stall)             r_out_valid <= 1'b0;
            unique case (r_state)
                BS_IDLE: begin
                    if (!i_q_empty) begin
                        r_job  <= i_job;
                        r_step <= (i_job.kind == JOB_START) ? STEP_PS : STEP_SL;
                        if (i_job.kind == JOB_START) begin
                            r_best_valid   <= 1'b0;
                            r_best_gain    <= '0;
                            r_best_feature <= '0;
                            r_best_bin     <= '0;
                            r_best_lg      <= '0;
                            r_best_lh      <= '0;
                            r_best_lc      <= '0;
                            r_best_rg      <= '0;
                            r_best_rh      <= '0;
                            r_best_rc      <= '0;
                        end
                    end
                end
                BS_MUL: begin
                    r_num      <= (r_step == STEP_PS || r_step == STEP_SL || r_step == STEP_SR)
                                  ? sq[DIV_NUM_W-1:0] : DIV_NUM_W'({mag, 16'd0});
                    r_den      <= {1'b0, op_h} + {1'b0, i_cfg.lambda_reg};
                    r_mag_zero <= mag == '0;
                    r_g_pos    <= !op_g[31] && (op_g != '0);
                end
                BS_POST: begin
                    unique case (r_step)
                        STEP_PS: r_parent_score <= score_val;
                        STEP_SL: begin
                            r_score_l <= score_val;
                            r_step    <= STEP_SR;
                        end
                        STEP_SR: r_score_r <= score_val;
                        STEP_LL: begin
                            r_leaf_l <= leaf_val;
                            r_step   <= STEP_LR;
                        end
                        STEP_LR: r_leaf_r <= leaf_val;
                        default: ;
                    endcase
                end
                BS_GAIN: begin
                    if (better) begin
                        r_best_valid   <= 1'b1;
                        r_best_gain    <= gain;
                        r_best_feature <= r_job.feature;
                        r_best_bin     <= r_job.bin_index;
                        r_best_lg      <= r_job.lg;
                        r_best_lh      <= r_job.lh;
                        r_best_lc      <= r_job.lc;
                        r_best_rg      <= r_job.rg;
                        r_best_rh      <= r_job.rh;
                        r_best_rc      <= r_job.rc;
                    end
                end
                BS_EMIT: r_step <= STEP_LL;
                BS_OUT: begin
                    if (out_free) begin
                        if (r_best_valid) begin
                            r_out.split_valid <= 1'b1;
                            r_out.sel_feature <= r_best_feature;
                            r_out.sel_bin     <= r_best_bin;
                            r_out.split_gain  <= r_best_gain;
                            r_out.left_grad   <= r_best_lg;
                            r_out.left_hess   <= r_best_lh;
                            r_out.left_count  <= r_best_lc;
                            r_out.right_grad  <= r_best_rg;
                            r_out.right_hess  <= r_best_rh;
                            r_out.right_count <= r_best_rc;
                            r_out.leaf_left   <= r_leaf_l;
                            r_out.leaf_right  <= r_leaf_r;
                        end else begin
                            r_out <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule

@@ tb/hsf_split_checker.sv @@
// Split finder checker: follows config writes and requests, predicts results and compares.
module hsf_split_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  hsf_pkg::t_in_item  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  hsf_pkg::t_out_item i_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_results,
    output int                 o_splits
);
    import hsf_pkg::*;

    localparam longint SAT_G_MAX = 64'sd2147483647;
    localparam longint SAT_G_MIN = -64'sd2147483648;
    localparam longint SAT_GAIN_MAX = 64'sd140737488355327;
    localparam longint SAT_GAIN_MIN = -64'sd140737488355328;

    t_cfg      cfg;
    t_out_item split_results_q[$];

    longint    par_g, par_score, pre_g, top_gain;
    bit [63:0] par_h, par_c, pre_h, pre_c;
    bit        top_valid;
    bit [7:0]  top_feat, top_bin;
    longint    top_lg, top_lv, top_rv;
    bit [63:0] top_lh, top_lc;

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint score_of(input longint g, input bit [63:0] h);
        bit [63:0] d, m, q;
        d = h + cfg.lambda_reg;
        m = g < 0 ? -g : g;
        if (d == 0) return m == 0 ? 0 : SAT_GAIN_MAX;
        q = (m * m) / d;
        return q > SAT_GAIN_MAX ? SAT_GAIN_MAX : longint'(q);
    endfunction

    function automatic longint leaf_of(input longint g, input bit [63:0] h);
        bit [63:0] d, m, q;
        d = h + cfg.lambda_reg;
        m = g < 0 ? -g : g;
        if (m == 0) return 0;
        if (d == 0) return g > 0 ? SAT_G_MIN : SAT_G_MAX;
        q = (m << 16) / d;
        if (g > 0) return q > 64'd2147483648 ? SAT_G_MIN : -longint'(q);
        return q > 64'd2147483647 ? SAT_G_MAX : longint'(q);
    endfunction

    task automatic right_side(input longint lg, input bit [63:0] lh, input bit [63:0] lc,
                              output longint rg, output bit [63:0] rh, output bit [63:0] rc);
        rg = clamp(par_g - lg, SAT_G_MIN, SAT_G_MAX);
        rh = par_h >= lh ? par_h - lh : 0;
        rc = par_c >= lc ? par_c - lc : 0;
    endtask

    task automatic predict(input t_in_item it);
        longint    g, rg, gain;
        bit [63:0] h, c, rh, rc, nb;
        t_out_item r;
        g = longint'(it.grad_sum);
        h = it.hess_sum;
        c = it.sample_count;
        if (it.op == 1'b0) begin
            par_g = g; par_h = h; par_c = c;
            par_score = score_of(g, h);
            pre_g = 0; pre_h = 0; pre_c = 0;
            top_valid = 0; top_gain = 0; top_feat = 0; top_bin = 0;
            top_lg = 0; top_lh = 0; top_lc = 0; top_lv = 0; top_rv = 0;
            return;
        end
        nb = cfg.num_bins < 2 ? 2 : (cfg.num_bins > BIN_LIMIT ? BIN_LIMIT : cfg.num_bins);
        // feature is 8 bits wide, so it is always below the feature limit
        if (it.bin_index == 0) begin
            pre_g = 0; pre_h = 0; pre_c = 0;
        end
        pre_g = clamp(pre_g + g, SAT_G_MIN, SAT_G_MAX);
        pre_h = pre_h + h > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : pre_h + h;
        pre_c = pre_c + c > 64'hFF_FFFF ? 64'hFF_FFFF : pre_c + c;
        if (it.bin_index < nb - 1) begin
            right_side(pre_g, pre_h, pre_c, rg, rh, rc);
            if (pre_c >= cfg.min_count && rc >= cfg.min_count &&
                pre_h >= cfg.min_hess && rh >= cfg.min_hess) begin
                gain = (score_of(pre_g, pre_h) + score_of(rg, rh) - par_score) / 2;
                gain = clamp(gain, SAT_GAIN_MIN, SAT_GAIN_MAX);
                if ((!top_valid || gain > top_gain) && gain >= longint'(cfg.gain_floor)) begin
                    top_valid = 1;
                    top_gain = gain;
                    top_feat = it.feature;
                    top_bin = it.bin_index;
                    top_lg = pre_g; top_lh = pre_h; top_lc = pre_c;
                    top_lv = leaf_of(pre_g, pre_h);
                    top_rv = leaf_of(rg, rh);
                end
            end
        end
        if (!it.last) return;
        r = '0;
        if (top_valid) begin
            right_side(top_lg, top_lh, top_lc, rg, rh, rc);
            r.split_valid = 1'b1;
            r.sel_feature = top_feat;
            r.sel_bin = top_bin;
            r.split_gain = top_gain[47:0];
            r.left_grad = top_lg[31:0];
            r.left_hess = top_lh[31:0];
            r.left_count = top_lc[23:0];
            r.right_grad = rg[31:0];
            r.right_hess = rh[31:0];
            r.right_count = rc[23:0];
            r.leaf_left = top_lv[31:0];
            r.leaf_right = top_rv[31:0];
        end
        split_results_q = {split_results_q, r};
    endtask

    task automatic cmp(input string name, input logic [63:0] want, input logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item e, a;
        if (!i_rst_n) begin
            cfg.lambda_reg <= 32'd65536;
            cfg.min_hess <= 32'd65536;
            cfg.min_count <= 24'd20;
            cfg.gain_floor <= 32'd0;
            cfg.num_bins <= 9'd256;
            par_g = 0; par_h = 0; par_c = 0; par_score = 0;
            pre_g = 0; pre_h = 0; pre_c = 0;
            top_valid = 0; top_gain = 0; top_feat = 0; top_bin = 0;
            top_lg = 0; top_lh = 0; top_lc = 0; top_lv = 0; top_rv = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[4:2]))
                    REG_LAMBDA:      cfg.lambda_reg <= pwdata;
                    REG_MIN_WEIGHT:  cfg.min_hess <= pwdata;
                    REG_MIN_SAMPLES: cfg.min_count <= pwdata[23:0];
                    REG_MIN_GAIN:    cfg.gain_floor <= pwdata;
                    REG_NUM_BINS:    cfg.num_bins <= pwdata[8:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) predict(i_in_data);
            if (i_out_valid && !i_out_stall) begin
                a = i_out_data;
                if (split_results_q.size() == 0) begin
                    $error("result with no request pending: %h", a);
                    o_fail_count++;
                end else begin
                    e = split_results_q.pop_front();
                    o_results++;
                    if (e.split_valid) o_splits++;
                    cmp("split_valid", e.split_valid, a.split_valid);
                    cmp("sel_feature", e.sel_feature, a.sel_feature);
                    cmp("sel_bin", e.sel_bin, a.sel_bin);
                    cmp("split_gain", e.split_gain, a.split_gain);
                    cmp("left_grad", e.left_grad, a.left_grad);
                    cmp("left_hess", e.left_hess, a.left_hess);
                    cmp("left_count", e.left_count, a.left_count);
                    cmp("right_grad", e.right_grad, a.right_grad);
                    cmp("right_hess", e.right_hess, a.right_hess);
                    cmp("right_count", e.right_count, a.right_count);
                    cmp("leaf_left", e.leaf_left, a.leaf_left);
                    cmp("leaf_right", e.leaf_right, a.leaf_right);
                end
            end
        end
        o_pending <= split_results_q.size();
    end

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        o_results = 0;
        o_splits = 0;
    end
endmodule

@@ tb/tb_top.sv @@
// Testbench top for the histogram split finder: stimulus, config phases, verdict.
module tb_top;
    import hsf_pkg::*;

    localparam int RUN_LIMIT = 4000000;
    localparam int SETTLE = 400;

    logic      i_clk, i_rst_n;
    logic      in_valid, in_stall, out_valid, out_stall;
    t_in_item  in_data;
    t_out_item out_data;
    logic      psel, penable, pwrite, pready;
    logic [4:0]  paddr;
    logic [31:0] pwdata, prdata;
    int        fail_count, pending, results, splits;
    int        cyc, sent, bins_eff;
    bit        hold_req, hold_done;
    int        hold_cnt, stall_cnt;
    t_in_item  set_q[$];

    histogram_split_finder_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    hsf_split_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_results(results), .o_splits(splits)
    );

    always begin
        i_clk = 1'b1; #2;
        i_clk = 1'b0; #2;
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > RUN_LIMIT) begin
            $display("timeout after %0d cycles", cyc);
            $display("Verification failed");
            $finish;
        end
    end

    // gap length: mostly none, some short, a few long; none in quiet windows
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (cyc[11]) return 0;
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            out_stall <= 1'b1;
        end else if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_cnt <= 800;
            out_stall <= 1'b1;
        end else if (stall_cnt > 0) begin
            stall_cnt <= stall_cnt - 1;
            out_stall <= 1'b1;
        end else begin
            stall_cnt <= gap_len();
            out_stall <= 1'b0;
        end
    end

    task automatic send(input t_in_item it);
        int g;
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        sent++;
        g = gap_len();
        if (g > 0) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
            repeat (g - 1) @(negedge i_clk);
        end
    endtask

    task automatic reg_write(input t_reg_idx idx, input logic [31:0] val);
        @(negedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic drain();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic configure(input logic [31:0] lam, input logic [31:0] mcw,
                             input logic [31:0] msl, input logic [31:0] msg,
                             input logic [31:0] nb);
        drain();
        reg_write(REG_LAMBDA, lam);
        reg_write(REG_MIN_WEIGHT, mcw);
        reg_write(REG_MIN_SAMPLES, msl);
        reg_write(REG_MIN_GAIN, msg);
        reg_write(REG_NUM_BINS, nb);
        bins_eff = nb[8:0] < 2 ? 2 : (nb[8:0] > BIN_LIMIT ? BIN_LIMIT : int'(nb[8:0]));
    endtask

    function automatic t_in_item mk(input logic op, input logic [7:0] f, input logic [7:0] b,
                                    input logic [31:0] g, input logic [31:0] h,
                                    input logic [23:0] c, input logic lst);
        t_in_item it;
        it.op = op; it.feature = f; it.bin_index = b;
        it.grad_sum = g; it.hess_sum = h; it.sample_count = c; it.last = lst;
        return it;
    endfunction

    // one node search: start request built from the first feature's sums (now and then random), then all bins
    task automatic run_node(input int nfeat);
        longint    pg;
        bit [63:0] ph, pc;
        t_in_item  it;
        int        nb;
        set_q.delete();
        pg = 0; ph = 0; pc = 0;
        for (int f = 0; f < nfeat; f++) begin
            logic [7:0] fid;
            fid = 8'($urandom_range(0, 255));
            nb = bins_eff;
            // now and then a bin beyond the bin count
            if (nb < 256 && $urandom_range(0, 9) == 0) nb = nb + 1;
            for (int b = 0; b < nb; b++) begin
                if ($urandom_range(0, 24) == 0)
                    it = mk(1'b1, fid, 8'(b), $urandom, $urandom, 24'($urandom), 1'b0);
                else
                    it = mk(1'b1, fid, 8'(b), 32'($urandom_range(0, 2 * 1048576) - 1048576),
                            32'($urandom_range(0, 262144)), 24'($urandom_range(0, 40)), 1'b0);
                if (f == 0) begin
                    pg += longint'(it.grad_sum); ph += it.hess_sum; pc += it.sample_count;
                end
                set_q.push_back(it);
            end
        end
        set_q[$].last = 1'b1;
        if ($urandom_range(0, 9) == 0)
            send(mk(1'b0, 8'd0, 8'd0, $urandom, $urandom, 24'($urandom),
                    1'($urandom_range(0, 1))));
        else
            send(mk(1'b0, 8'($urandom), 8'($urandom), pg[31:0], ph[31:0], pc[23:0], 1'b0));
        foreach (set_q[i]) send(set_q[i]);
        // now and then a repeated final bin
        if ($urandom_range(0, 7) == 0) send(set_q[$]);
    endtask

    task automatic run_phase(input int n_items);
        int goal;
        goal = sent + n_items;
        while (sent < goal) run_node($urandom_range(1, 3));
    endtask

    initial begin
        cyc = 0; sent = 0; bins_eff = 256;
        hold_req = 0; hold_done = 0; hold_cnt = 0; stall_cnt = 0;
        in_valid = 1'b0; in_data = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // a final bin with no start request, against the zero parent
        send(mk(1'b1, 8'd3, 8'd0, 32'h0001_0000, 32'h0002_0000, 24'd30, 1'b1));
        // start request with last set emits nothing; extreme parent
        send(mk(1'b0, 8'hFF, 8'hFF, 32'h7FFF_FFFF, 32'h0, 24'hFF_FFFF, 1'b1));
        // prefix and right side saturation
        send(mk(1'b1, 8'd0, 8'd0, 32'h8000_0000, 32'hFFFF_FFFF, 24'hFF_FFFF, 1'b0));
        send(mk(1'b1, 8'd0, 8'd1, 32'h8000_0000, 32'hFFFF_FFFF, 24'hFF_FFFF, 1'b0));
        send(mk(1'b1, 8'd0, 8'd2, 32'h7FFF_FFFF, 32'h0, 24'h0, 1'b1));
        send(mk(1'b1, 8'd0, 8'd2, 32'h7FFF_FFFF, 32'h0, 24'h0, 1'b1));
        // ordinary node with a clear split
        send(mk(1'b0, 8'd0, 8'd0, 32'h0001_0000, 32'h000A_0000, 24'd100, 1'b0));
        send(mk(1'b1, 8'hFF, 8'd0, 32'hFFFE_0000, 32'h0003_0000, 24'd30, 1'b0));
        send(mk(1'b1, 8'hFF, 8'd1, 32'h0003_0000, 32'h0003_0000, 24'd40, 1'b1));
        send(mk(1'b1, 8'hAA, 8'd0, 32'h0005_0000, 32'h0004_0000, 24'd50, 1'b0));
        send(mk(1'b1, 8'hAA, 8'd1, 32'hFFFB_0000, 32'h0001_0000, 24'd25, 1'b1));
        send(mk(1'b1, 8'h55, 8'hFF, 32'h0, 32'h0, 24'd0, 1'b1));

        configure(32'd65536, 32'd65536, 32'd20, 32'd0, 32'd8);
        hold_req = 1;
        run_phase(150);
        // pause until the block has answered everything
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        run_phase(150);
        configure(32'd0, 32'd0, 32'd0, 32'd0, 32'd4);
        send(mk(1'b0, 8'd0, 8'd0, 32'h0, 32'h0, 24'd0, 1'b0));
        send(mk(1'b1, 8'd1, 8'd0, 32'h0, 32'h0, 24'd0, 1'b0));
        send(mk(1'b1, 8'd1, 8'd1, 32'h0001_0000, 32'h0, 24'd1, 1'b1));
        run_phase(100);
        configure(32'hFFFF_FFFF, 32'd0, 32'd5, 32'd0, 32'd0);
        run_phase(80);
        configure(32'd32768, 32'h8000, 32'd10, 32'hFFFF_FFFF, 32'd6);
        run_phase(80);
        configure(32'd65536, 32'd65536, 32'hFF_FFFF, 32'd0, 32'd3);
        run_phase(30);
        configure(32'd65536, 32'd65536, 32'd20, 32'd0, 32'd511);
        run_node(1);
        configure(32'd16384, 32'd1024, 32'd3, 32'd4096, 32'd5);
        run_phase(240);

        drain();
        $display("%0d requests sent over 8 register settings, %0d results checked (%0d splits)",
                 sent, results, splits);
        $display("covered zero denominators, saturation, bin count limits and output back-pressure");
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
